// File: rtl/pha_pkg.sv
package pha_pkg;

  // Pool geometry
  localparam int POOL_SIZE = 16;
  localparam int HANDLE_W  = 6;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 3;
  localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  // Operation codes
  localparam logic [1:0] OP_SINGLE  = 2'd0;
  localparam logic [1:0] OP_BATCH   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NONE_FREE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic                capture;
    logic                pop;
    logic                release_h;
    logic                emit;
    logic                batch_load;
    logic                batch_step;
    logic [STATUS_W-1:0] status;
    logic                last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       count_zero;
    logic       too_big;
    logic       empty;
    logic       release_ok;
    logic       out_free;
    logic       rem_one;
  } stat_t;

endpackage

// File: rtl/pool_handle_allocator.sv
// Handle allocator over a fixed pool of POOL_SIZE object slots.
// Input channel (in_valid/in_stall) carries op, count and handle; an item is
// taken when in_valid is high and in_stall is low. Output channel
// (out_valid/out_stall) carries granted_handle, status, last and free_left.
// Op 0 pops one free handle, op 1 grants a batch of count handles or one
// refusal, op 2 returns an in-use handle to the free stack.
// Timing: a single request or release is captured, then its result is loaded
// into the output register in the execute state once that register is free;
// the next item is accepted only after that, so a new item is not taken while
// the last is in work. A batch is captured, then loads the batch counter, then
// gives one handle per cycle from the free stack top while the receiver does
// not stall. A refused batch gives one result; a batch of zero and op 3 give
// no result. The controller captures the item, then read-modify-writes the
// free stack top and in-use map.
// Reset: all handles free, stacked in order, so the highest is granted first.
// When the receiver stalls, the pending result holds in the output register
// and the controller waits before loading the next result; a new item may
// still be accepted while a result waits.
module pool_handle_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [pha_pkg::COUNT_W-1:0]   count,
  input  logic [pha_pkg::HANDLE_W-1:0]  handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pha_pkg::HANDLE_W-1:0]  granted_handle,
  output logic [pha_pkg::STATUS_W-1:0]  status,
  output logic                          last,
  output logic [pha_pkg::COUNT_W-1:0]   free_left
);
  import pha_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pha_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .op             (op),
    .count          (count),
    .handle         (handle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted_handle (granted_handle),
    .status         (status),
    .last           (last),
    .free_left      (free_left)
  );

endmodule

// File: rtl/pha_datapath.sv
module pha_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  pha_pkg::cmd_t                     cmd,
  output pha_pkg::stat_t                    stat,
  input  logic [1:0]                        op,
  input  logic [pha_pkg::COUNT_W-1:0]       count,
  input  logic [pha_pkg::HANDLE_W-1:0]      handle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pha_pkg::HANDLE_W-1:0]      granted_handle,
  output logic [pha_pkg::STATUS_W-1:0]      status,
  output logic                              last,
  output logic [pha_pkg::COUNT_W-1:0]       free_left
);
  import pha_pkg::*;

  // Captured item
  logic [1:0]          op_q;
  logic [COUNT_W-1:0]  count_q;
  logic [HANDLE_W-1:0] handle_q;

  // Allocator state
  logic [HANDLE_W-1:0] stack [POOL_SIZE];
  logic [COUNT_W-1:0]  free_count;
  logic [POOL_SIZE-1:0] in_use;
  logic [COUNT_W-1:0]  remaining;

  logic [COUNT_W-1:0]  top_sel;
  logic [IDX_W-1:0]    top_idx;
  logic [IDX_W-1:0]    push_idx;
  logic [IDX_W-1:0]    rel_idx;
  logic [HANDLE_W-1:0] top_h;
  logic                in_range;
  logic [COUNT_W-1:0]  free_count_next;

  // Stack pointers and release check
  assign top_sel  = free_count - COUNT_W'(1);
  assign top_idx  = top_sel[IDX_W-1:0];
  assign push_idx = free_count[IDX_W-1:0];
  assign rel_idx  = handle_q[IDX_W-1:0];
  assign top_h    = stack[top_idx];
  assign in_range = ({1'b0, handle_q} < COUNT_W'(POOL_SIZE));

  always_comb begin
    if (cmd.pop) begin
      free_count_next = free_count - COUNT_W'(1);
    end else if (cmd.release_h) begin
      free_count_next = free_count + COUNT_W'(1);
    end else begin
      free_count_next = free_count;
    end
  end

  // Status to controller
  assign stat.op         = op_q;
  assign stat.count_zero = (count_q == '0);
  assign stat.too_big    = (count_q > free_count);
  assign stat.empty      = (free_count == '0);
  assign stat.release_ok = in_range && in_use[rel_idx] &&
                           (free_count < COUNT_W'(POOL_SIZE));
  assign stat.out_free   = !out_valid || !out_stall;
  assign stat.rem_one    = (remaining == COUNT_W'(1));

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= op;
      count_q  <= count;
      handle_q <= handle;
    end
  end

  // Free stack, count and in-use map
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POOL_SIZE; i++) begin
        stack[i] <= HANDLE_W'(i);
      end
      free_count <= COUNT_W'(POOL_SIZE);
      in_use     <= '0;
    end else begin
      free_count <= free_count_next;
      if (cmd.pop) begin
        in_use[top_h[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.release_h) begin
        stack[push_idx] <= handle_q;
        in_use[rel_idx] <= 1'b0;
      end
    end
  end

  // Batch counter
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (cmd.batch_load) begin
      remaining <= count_q;
    end else if (cmd.batch_step) begin
      remaining <= remaining - COUNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      granted_handle <= cmd.pop ? top_h : '0;
      status         <= cmd.status;
      last           <= cmd.last;
      free_left      <= free_count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= COUNT_W'(POOL_SIZE))
    else $error("free count above pool size");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (free_count != '0))
    else $error("pop from empty free stack");

  a_conserve: assert property (@(posedge clk) disable iff (rst)
    ($countones(in_use) + int'(free_count)) == POOL_SIZE)
    else $error("in-use map and free count disagree");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result overwrote a pending result");
`endif

endmodule

// File: rtl/pha_ctrl.sv
module pha_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  pha_pkg::stat_t stat,
  output pha_pkg::cmd_t  cmd
);
  import pha_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_BATCH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  // Command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_SINGLE: begin
            if (stat.out_free) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.pop    = !stat.empty;
              cmd.status = stat.empty ? ST_NONE_FREE : ST_GRANTED;
              state_next = S_IDLE;
            end
          end
          OP_BATCH: begin
            if (stat.count_zero) begin
              state_next = S_IDLE;
            end else if (stat.too_big) begin
              if (stat.out_free) begin
                cmd.emit   = 1'b1;
                cmd.last   = 1'b1;
                cmd.status = ST_REFUSED;
                state_next = S_IDLE;
              end
            end else begin
              cmd.batch_load = 1'b1;
              state_next     = S_BATCH;
            end
          end
          OP_RELEASE: begin
            if (stat.out_free) begin
              cmd.emit      = 1'b1;
              cmd.last      = 1'b1;
              cmd.release_h = stat.release_ok;
              cmd.status    = stat.release_ok ? ST_RELEASED : ST_IGNORED;
              state_next    = S_IDLE;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_BATCH: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.pop        = 1'b1;
          cmd.batch_step = 1'b1;
          cmd.status     = ST_GRANTED;
          cmd.last       = stat.rem_one;
          if (stat.rem_one) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
